// ----- rtl/twacpu_pkg.sv -----
// ---------------------------------------------------------------------------
// twacpu_pkg
// Shared types and constants of the two-slot word accumulator CPU.
// ---------------------------------------------------------------------------
package twacpu_pkg;

   localparam int unsigned FIELD_BITS = 11;
   localparam int unsigned IMM_FIRST  = 24;
   localparam int unsigned OPC_SHIFT  = 27;
   localparam int unsigned PC_STEP    = 4;
   localparam int unsigned CNT_BITS   = 4;

   typedef enum logic [4:0] {
      OP_HLT    = 5'd0,  OP_NOP   = 5'd1,  OP_ADD    = 5'd2,  OP_SUB   = 5'd3,
      OP_MUL    = 5'd4,  OP_DIV   = 5'd5,  OP_CMP    = 5'd6,  OP_XCHG  = 5'd7,
      OP_AND    = 5'd8,  OP_OR    = 5'd9,  OP_XOR    = 5'd10, OP_NOT   = 5'd11,
      OP_JE     = 5'd12, OP_JNE   = 5'd13, OP_JL     = 5'd14, OP_JLE   = 5'd15,
      OP_JG     = 5'd16, OP_JGE   = 5'd17, OP_JMP    = 5'd18, OP_LDA   = 5'd19,
      OP_LDB    = 5'd20, OP_STA   = 5'd21, OP_STB    = 5'd22, OP_LDRB  = 5'd23,
      OP_MOVIAL = 5'd24, OP_MOVIAH = 5'd25, OP_ADDIA = 5'd26, OP_SUBIA = 5'd27,
      OP_MULIA  = 5'd28, OP_DIVIA = 5'd29, OP_LSH    = 5'd30, OP_RSH   = 5'd31
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRAP_HI, ST_WRAP_LO, ST_WRITE, ST_FETCH,
      ST_EXEC, ST_LOAD, ST_STORE, ST_DIVIDE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PUR_WRITE, PUR_FETCH, PUR_LOAD, PUR_STORE
   } purpose_type;

   typedef enum logic [1:0] {
      SRC_LOAD, SRC_PC, SRC_FIELD, SRC_ACCB
   } addr_src_type;

   typedef enum logic [1:0] {
      WD_ZERO, WD_REQ, WD_HI, WD_LO
   } wdata_type;

   typedef struct packed {
      logic        op;
      logic [10:0] load_addr;
      logic [7:0]  load_data;
   } req_type;

   typedef struct packed {
      logic [10:0] prog_counter;
      logic [15:0] acc_a_out;
      logic [15:0] acc_b_out;
      logic        eq_flag;
      logic        lt_flag;
      logic        gt_flag;
      logic        halted;
      logic        right_next;
      logic [4:0]  executed_opcode;
      logic        div_zero;
   } rsp_type;

   typedef struct packed {
      logic         accept;
      addr_src_type src;
      logic         wrap_hi;
      logic         wrap_lo;
      logic         addr_inc;
      logic         mem_we;
      wdata_type    wdata;
      logic         shift_word;
      logic         exec;
      logic         div_step;
      logic         div_last;
      logic         load_done;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opc;
      logic       pend;
      logic       halt;
      logic       div_zero;
      logic       addr_last;
   } dp_stat_type;

endpackage

// ----- rtl/twacpu_dpath.sv -----
// ---------------------------------------------------------------------------
// twacpu_dpath
// Machine state, byte memory, address wrap unit, ALU and serial divider.
// ---------------------------------------------------------------------------
module twacpu_dpath #(
   parameter int unsigned MEM_BYTES = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  twacpu_pkg::req_type    req_data,
   input  twacpu_pkg::dp_cmd_type cmd,
   output twacpu_pkg::dp_stat_type stat,
   output twacpu_pkg::rsp_type    rsp_data
);
   import twacpu_pkg::*;

   localparam int unsigned AW = $clog2(MEM_BYTES);

   logic [7:0]    mem_q [MEM_BYTES];
   logic [7:0]    rdata_ff;
   logic [7:0]    wdata;

   req_type       req_ff, req_in;
   logic [10:0]   pc_ff, pc_in;
   logic [15:0]   a_ff, a_in, b_ff, b_in;
   logic [2:0]    flags_ff, flags_in;
   logic [15:0]   right_ff, right_in;
   logic          pend_ff, pend_in, halt_ff, halt_in;
   logic          is_right_ff, is_right_in;
   logic [15:0]   instr_ff, instr_in;
   logic [31:0]   word_ff, word_in;
   logic [4:0]    exec_op_ff, exec_op_in;
   logic          dz_ff, dz_in;
   logic [15:0]   red_ff, red_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [15:0]   quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;

   logic [15:0]   instr;
   opcode_type    opc;
   logic [10:0]   fld;
   logic [15:0]   fld16, src_val, ld_val, divisor, rem_nx, quo_nx;
   logic [16:0]   div_r;
   logic [31:0]   product;
   logic          taken, is_jump;
   opcode_type    cur_opc;

   // Six compare-subtract steps of the byte address modulo MEM_BYTES.
   function automatic logic [15:0] red6(input logic [15:0] v, input logic [3:0] top);
      logic [15:0] r;
      logic [22:0] m_sh;
      r = v;
      for (int j = 0; j < 6; j++) begin
         m_sh = 23'(MEM_BYTES) << (top - 4'(j));
         if ({7'd0, r} >= m_sh) r = r - m_sh[15:0];
      end
      return r;
   endfunction

   assign instr   = is_right_ff ? instr_ff : word_ff[31:16];
   assign opc     = opcode_type'(instr[15:11]);
   assign fld     = instr[10:0];
   assign fld16   = {5'd0, fld};
   assign cur_opc = opcode_type'(instr_ff[15:11]);
   assign divisor = (opc == OP_DIV) ? b_ff : fld16;
   assign ld_val  = {word_ff[7:0], rdata_ff};
   assign div_r   = {rem_ff, quo_ff[15]};
   assign rem_nx  = (div_r >= {1'b0, dvs_ff}) ? 16'(div_r - {1'b0, dvs_ff}) : div_r[15:0];
   assign quo_nx  = {quo_ff[14:0], div_r >= {1'b0, dvs_ff}};
   assign product = a_ff * ((opc == OP_MUL) ? b_ff : fld16);

   always_comb begin
      case (cmd.src)
         SRC_LOAD:  src_val = {5'd0, req_ff.load_addr};
         SRC_PC:    src_val = {5'd0, pc_ff};
         SRC_FIELD: src_val = {5'd0, instr_ff[10:0]};
         default:   src_val = b_ff;
      endcase
      case (cmd.wdata)
         WD_ZERO: wdata = 8'd0;
         WD_REQ:  wdata = req_ff.load_data;
         WD_HI:   wdata = (cur_opc == OP_STB) ? b_ff[15:8] : a_ff[15:8];
         default: wdata = (cur_opc == OP_STB) ? b_ff[7:0] : a_ff[7:0];
      endcase
      case (opc)
         OP_JE:   taken = flags_ff[0];
         OP_JNE:  taken = !flags_ff[0];
         OP_JL:   taken = flags_ff[1];
         OP_JLE:  taken = flags_ff[0] || flags_ff[1];
         OP_JG:   taken = flags_ff[2];
         OP_JGE:  taken = flags_ff[2] || flags_ff[0];
         OP_JMP:  taken = 1'b1;
         default: taken = 1'b0;
      endcase
      is_jump = (opc >= OP_JE) && (opc <= OP_JMP);
   end

   always_comb begin
      req_in = req_ff;     pc_in = pc_ff;       a_in = a_ff;       b_in = b_ff;
      flags_in = flags_ff; right_in = right_ff; pend_in = pend_ff; halt_in = halt_ff;
      is_right_in = is_right_ff; instr_in = instr_ff; word_in = word_ff;
      exec_op_in = exec_op_ff;   dz_in = dz_ff;   red_in = red_ff;   addr_in = addr_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;

      if (cmd.accept) begin
         req_in      = req_data;
         is_right_in = pend_ff;
         exec_op_in  = OP_HLT;
         dz_in       = 1'b0;
         if (pend_ff) instr_in = right_ff;
      end
      if (cmd.wrap_hi) red_in = red6(src_val, 4'd11);
      if (cmd.wrap_lo) addr_in = AW'(red6(red_ff, 4'd5));
      else if (cmd.addr_inc)
         addr_in = (addr_ff == AW'(MEM_BYTES - 1)) ? '0 : addr_ff + 1'b1;
      if (cmd.shift_word) word_in = {word_ff[23:0], rdata_ff};

      if (cmd.exec) begin
         instr_in   = instr;
         exec_op_in = opc;
         if (!is_right_ff) right_in = word_ff[15:0];
         pend_in = !is_right_ff;
         if (is_jump && taken) begin
            pc_in   = fld;
            pend_in = 1'b0;
         end else if (opc != OP_HLT && is_right_ff) begin
            pc_in = pc_ff + 11'(PC_STEP);
         end
         case (opc)
            OP_HLT:    halt_in = 1'b1;
            OP_ADD:    a_in = a_ff + b_ff;
            OP_SUB:    a_in = a_ff - b_ff;
            OP_MUL,
            OP_MULIA:  a_in = product[15:0];
            OP_DIV,
            OP_DIVIA:  begin
               if (divisor == 16'd0) begin
                  a_in  = 16'hFFFF;
                  dz_in = 1'b1;
               end
               quo_in = a_ff;
               rem_in = 16'd0;
               dvs_in = divisor;
            end
            OP_CMP:    flags_in = {a_ff > b_ff, a_ff < b_ff, a_ff == b_ff};
            OP_XCHG:   begin
               a_in = b_ff;
               b_in = a_ff;
            end
            OP_AND:    a_in = a_ff & b_ff;
            OP_OR:     a_in = a_ff | b_ff;
            OP_XOR:    a_in = a_ff ^ b_ff;
            OP_NOT:    a_in = ~a_ff;
            OP_MOVIAL: a_in = {8'd0, fld[7:0]};
            OP_MOVIAH: a_in = {fld[7:0], a_ff[7:0]};
            OP_ADDIA:  a_in = a_ff + fld16;
            OP_SUBIA:  a_in = a_ff - fld16;
            OP_LSH:    a_in = (fld >= 11'd16) ? 16'd0 : a_ff << fld[3:0];
            OP_RSH:    a_in = (fld >= 11'd16) ? 16'd0 : a_ff >> fld[3:0];
            default:   ;
         endcase
      end

      if (cmd.div_step) begin
         quo_in = quo_nx;
         rem_in = rem_nx;
         if (cmd.div_last) a_in = quo_nx;
      end
      if (cmd.load_done) begin
         if (cur_opc == OP_LDB) b_in = ld_val;
         else a_in = ld_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; a_ff <= '0; b_ff <= '0; flags_ff <= '0; right_ff <= '0;
         pend_ff <= 1'b0; halt_ff <= 1'b0; addr_ff <= '0;
      end else begin
         pc_ff <= pc_in; a_ff <= a_in; b_ff <= b_in; flags_ff <= flags_in;
         right_ff <= right_in; pend_ff <= pend_in; halt_ff <= halt_in; addr_ff <= addr_in;
      end
      req_ff <= req_in; is_right_ff <= is_right_in; instr_ff <= instr_in;
      word_ff <= word_in; exec_op_ff <= exec_op_in; dz_ff <= dz_in; red_ff <= red_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) mem_q[addr_ff] <= wdata;
      rdata_ff <= mem_q[addr_ff];
   end

   assign stat.opc       = opc;
   assign stat.pend      = pend_ff;
   assign stat.halt      = halt_ff;
   assign stat.div_zero  = (divisor == 16'd0);
   assign stat.addr_last = (addr_ff == AW'(MEM_BYTES - 1));

   assign rsp_data.prog_counter    = pc_ff;
   assign rsp_data.acc_a_out       = a_ff;
   assign rsp_data.acc_b_out       = b_ff;
   assign rsp_data.eq_flag         = flags_ff[0];
   assign rsp_data.lt_flag         = flags_ff[1];
   assign rsp_data.gt_flag         = flags_ff[2];
   assign rsp_data.halted          = halt_ff;
   assign rsp_data.right_next      = pend_ff;
   assign rsp_data.executed_opcode = exec_op_ff;
   assign rsp_data.div_zero        = dz_ff;

endmodule

// ----- rtl/twacpu_ctrl.sv -----
// ---------------------------------------------------------------------------
// twacpu_ctrl
// Sequencer: memory clear, address wrap, fetch, execute, load, store, divide.
// ---------------------------------------------------------------------------
module twacpu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_op,
   input  twacpu_pkg::dp_stat_type stat,
   output twacpu_pkg::dp_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import twacpu_pkg::*;

   state_type             state_ff, state_in;
   purpose_type           pur_ff, pur_in;
   addr_src_type          src_ff, src_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pur_ff   <= PUR_WRITE;
         src_ff   <= SRC_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pur_ff   <= pur_in;
         src_ff   <= src_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pur_in   = pur_ff;
      src_in   = src_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.src  = src_ff;
      cmd.wdata = WD_ZERO;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_inc = 1'b1;
            if (stat.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (!req_op) begin
                  pur_in   = PUR_WRITE;
                  src_in   = SRC_LOAD;
                  state_in = ST_WRAP_HI;
               end else if (stat.halt) begin
                  state_in = ST_DONE;
               end else if (stat.pend) begin
                  state_in = ST_EXEC;
               end else begin
                  pur_in   = PUR_FETCH;
                  src_in   = SRC_PC;
                  state_in = ST_WRAP_HI;
               end
            end
         end
         ST_WRAP_HI: begin
            cmd.wrap_hi = 1'b1;
            state_in    = ST_WRAP_LO;
         end
         ST_WRAP_LO: begin
            cmd.wrap_lo = 1'b1;
            cnt_in      = '0;
            unique case (pur_ff)
               PUR_WRITE: state_in = ST_WRITE;
               PUR_FETCH: state_in = ST_FETCH;
               PUR_LOAD:  state_in = ST_LOAD;
               default:   state_in = ST_STORE;
            endcase
         end
         ST_WRITE: begin
            cmd.mem_we = 1'b1;
            cmd.wdata  = WD_REQ;
            state_in   = ST_DONE;
         end
         ST_FETCH: begin
            // read one byte per cycle, shift in the byte issued the cycle before
            cmd.addr_inc   = 1'b1;
            cmd.shift_word = (cnt_ff != '0);
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(4)) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            unique case (stat.opc)
               OP_LDA, OP_LDB: begin
                  pur_in   = PUR_LOAD;
                  src_in   = SRC_FIELD;
                  state_in = ST_WRAP_HI;
               end
               OP_LDRB: begin
                  pur_in   = PUR_LOAD;
                  src_in   = SRC_ACCB;
                  state_in = ST_WRAP_HI;
               end
               OP_STA, OP_STB: begin
                  pur_in   = PUR_STORE;
                  src_in   = SRC_FIELD;
                  state_in = ST_WRAP_HI;
               end
               OP_DIV, OP_DIVIA:
                  state_in = stat.div_zero ? ST_DONE : ST_DIVIDE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_LOAD: begin
            cmd.addr_inc   = 1'b1;
            cmd.shift_word = (cnt_ff == CNT_BITS'(1));
            cmd.load_done  = (cnt_ff == CNT_BITS'(2));
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(2)) state_in = ST_DONE;
         end
         ST_STORE: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_inc = 1'b1;
            cmd.wdata    = (cnt_ff == '0) ? WD_HI : WD_LO;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff != '0) state_in = ST_DONE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (cnt_ff == '1);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == '1) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// ----- rtl/two_slot_word_accumulator_cpu_top.sv -----
// ---------------------------------------------------------------------------
// two_slot_word_accumulator_cpu_top
// Two-instructions-per-word accumulator CPU with byte-wide program memory.
// ---------------------------------------------------------------------------
// After reset the block clears its MEM_BYTES-byte memory, one byte a cycle, and
// holds busy high until it is done. A request is taken when start is high and
// busy low; its result shows on rsp_data for the one cycle rsp_valid is high
// and must be taken then. A byte write wraps the address, then writes; a step
// while halted goes straight to the result; a right-half step executes the held
// half; a left-half step wraps the address and fetches a four-byte word through
// the single memory port. Loads and stores add a wrap and the access; a divide
// runs the one-bit-a-cycle divider. busy drops the cycle after the result.
module two_slot_word_accumulator_cpu_top #(
   parameter int unsigned MEM_BYTES = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  twacpu_pkg::req_type req_data,
   output logic                rsp_valid,
   output twacpu_pkg::rsp_type rsp_data
);
   import twacpu_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   twacpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_data.op),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   twacpu_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/twacpu_checker.sv -----
// ---------------------------------------------------------------------------
// twacpu_checker
// Port-level checks of the request/result sequencing.
// ---------------------------------------------------------------------------
module twacpu_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input twacpu_pkg::rsp_type rsp_data
);
   import twacpu_pkg::*;

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy request");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe not followed by idle");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_zero) |-> (rsp_data.acc_a_out == 16'hFFFF))
      else $error("divide by zero result not forced");

endmodule

bind two_slot_word_accumulator_cpu_top twacpu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the two-slot word accumulator CPU: a short table of
// requests runs a hand-written program, then random programs are patched into
// memory and stepped through, each result checked against a predictor.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import twacpu_pkg::*;

   localparam int unsigned MEM_SIZE   = 2048;
   localparam int unsigned RAND_ITEMS = 1400;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } table_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predictor state
   logic [7:0]  mem_image [MEM_SIZE];
   logic [10:0] pc_q;
   logic [15:0] acc_a_q, acc_b_q, right_half_q;
   logic        eq_q, lt_q, gt_q, pend_q, halt_q;

   rsp_type       expected_q [$];
   table_row_type stim_table [$];
   int unsigned   idle_pct;
   int unsigned   n_items, n_steps, n_checked, n_errors, n_divzero, n_jumps;

   two_slot_word_accumulator_cpu_top #(.MEM_BYTES(MEM_SIZE)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [15:0] read_half(logic [10:0] a);
      return {mem_image[a], mem_image[a + 11'd1]};
   endfunction

   function automatic logic [15:0] encode(opcode_type o, logic [10:0] f);
      return {o, f};
   endfunction

   function automatic rsp_type cpu_step_predict(req_type r);
      rsp_type     o;
      logic [15:0] ins, t;
      logic [10:0] fld;
      opcode_type  opc;
      logic        taken, is_right, dz;
      opc   = OP_HLT;
      dz    = 1'b0;
      taken = 1'b0;
      if (!r.op) begin
         mem_image[r.load_addr] = r.load_data;
      end else if (!halt_q) begin
         if (!pend_q) begin
            ins          = read_half(pc_q);
            right_half_q = read_half(pc_q + 11'd2);
            pend_q       = 1'b1;
            is_right     = 1'b0;
         end else begin
            ins      = right_half_q;
            pend_q   = 1'b0;
            is_right = 1'b1;
         end
         opc = opcode_type'(ins[15:11]);
         fld = ins[10:0];
         n_steps++;
         case (opc)
            OP_HLT:  halt_q = 1'b1;
            OP_NOP:  ;
            OP_ADD:  acc_a_q = acc_a_q + acc_b_q;
            OP_SUB:  acc_a_q = acc_a_q - acc_b_q;
            OP_MUL:  acc_a_q = acc_a_q * acc_b_q;
            OP_DIV:  if (acc_b_q == 0) begin
               acc_a_q = 16'hFFFF;
               dz      = 1'b1;
            end else begin
               acc_a_q = acc_a_q / acc_b_q;
            end
            OP_CMP: begin
               eq_q = acc_a_q == acc_b_q;
               lt_q = acc_a_q < acc_b_q;
               gt_q = acc_a_q > acc_b_q;
            end
            OP_XCHG: begin
               t       = acc_a_q;
               acc_a_q = acc_b_q;
               acc_b_q = t;
            end
            OP_AND:    acc_a_q = acc_a_q & acc_b_q;
            OP_OR:     acc_a_q = acc_a_q | acc_b_q;
            OP_XOR:    acc_a_q = acc_a_q ^ acc_b_q;
            OP_NOT:    acc_a_q = ~acc_a_q;
            OP_JE:     taken = eq_q;
            OP_JNE:    taken = !eq_q;
            OP_JL:     taken = lt_q;
            OP_JLE:    taken = eq_q || lt_q;
            OP_JG:     taken = gt_q;
            OP_JGE:    taken = gt_q || eq_q;
            OP_JMP:    taken = 1'b1;
            OP_LDA:    acc_a_q = read_half(fld);
            OP_LDB:    acc_b_q = read_half(fld);
            OP_STA: begin
               mem_image[fld]         = acc_a_q[15:8];
               mem_image[fld + 11'd1] = acc_a_q[7:0];
            end
            OP_STB: begin
               mem_image[fld]         = acc_b_q[15:8];
               mem_image[fld + 11'd1] = acc_b_q[7:0];
            end
            OP_LDRB:   acc_a_q = read_half(acc_b_q[10:0]);
            OP_MOVIAL: acc_a_q = {8'h00, fld[7:0]};
            OP_MOVIAH: acc_a_q = {fld[7:0], acc_a_q[7:0]};
            OP_ADDIA:  acc_a_q = acc_a_q + fld;
            OP_SUBIA:  acc_a_q = acc_a_q - fld;
            OP_MULIA:  acc_a_q = acc_a_q * fld;
            OP_DIVIA:  if (fld == 0) begin
               acc_a_q = 16'hFFFF;
               dz      = 1'b1;
            end else begin
               acc_a_q = acc_a_q / fld;
            end
            OP_LSH:    acc_a_q = (fld >= 16) ? 16'h0 : acc_a_q << fld;
            default:   acc_a_q = (fld >= 16) ? 16'h0 : acc_a_q >> fld;
         endcase
         if (taken) begin
            pc_q   = fld;
            pend_q = 1'b0;
            n_jumps++;
         end else if (opc != OP_HLT && is_right) begin
            pc_q = pc_q + 11'd4;
         end
         if (dz) n_divzero++;
      end
      o.prog_counter    = pc_q;
      o.acc_a_out       = acc_a_q;
      o.acc_b_out       = acc_b_q;
      o.eq_flag         = eq_q;
      o.lt_flag         = lt_q;
      o.gt_flag         = gt_q;
      o.halted          = halt_q;
      o.right_next      = pend_q;
      o.executed_opcode = opc;
      o.div_zero        = dz;
      return o;
   endfunction

   // Drive one request and hold it until the block takes it.
   task automatic issue(req_type r, bit known = 1'b0, rsp_type typed = '0);
      rsp_type p;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      p = cpu_step_predict(r);
      expected_q.push_back(known ? typed : p);
      n_items++;
   endtask

   task automatic write_byte(logic [10:0] a, logic [7:0] d);
      req_type r;
      r.op        = 1'b0;
      r.load_addr = a;
      r.load_data = d;
      issue(r);
   endtask

   task automatic step_cpu();
      req_type r;
      r.op        = 1'b1;
      r.load_addr = 11'($urandom);
      r.load_data = 8'($urandom);
      issue(r);
   endtask

   // Overwrite a half holding hlt, or any half when forced, so random programs keep running.
   task automatic patch_half(logic [10:0] a, bit forced);
      logic [4:0]  opc;
      logic [10:0] f;
      if (mem_image[a][7:3] != 5'd0 && !forced) return;
      opc = 5'($urandom_range(1, 31));
      f   = ($urandom_range(1) != 0) ? 11'($urandom_range(0, 17)) : 11'($urandom);
      write_byte(a, {opc, f[10:8]});
      write_byte(a + 11'd1, f[7:0]);
   endtask

   task automatic add_row(req_type r, bit known = 1'b0, rsp_type typed = '0);
      table_row_type t;
      t.req   = r;
      t.known = known;
      t.rsp   = typed;
      stim_table.push_back(t);
   endtask

   task automatic add_write(logic [10:0] a, logic [7:0] d, bit known = 1'b0);
      add_row('{1'b0, a, d}, known, '0);
   endtask

   task automatic add_half(logic [10:0] a, logic [15:0] ins);
      add_write(a, ins[15:8]);
      add_write(a + 11'd1, ins[7:0]);
   endtask

   task automatic add_step(bit known = 1'b0, rsp_type typed = '0);
      add_row('{1'b1, 11'h7FF, 8'hFF}, known, typed);
   endtask

   task automatic check_field(string nm, int unsigned e, int unsigned a);
      if (e != a) begin
         n_errors++;
         if (n_errors <= 10)
            $display("mismatch %0s: expected %0h got %0h at %0t", nm, e, a, $realtime);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            check_field("prog_counter", e.prog_counter, rsp_data.prog_counter);
            check_field("acc_a_out", e.acc_a_out, rsp_data.acc_a_out);
            check_field("acc_b_out", e.acc_b_out, rsp_data.acc_b_out);
            check_field("eq_flag", e.eq_flag, rsp_data.eq_flag);
            check_field("lt_flag", e.lt_flag, rsp_data.lt_flag);
            check_field("gt_flag", e.gt_flag, rsp_data.gt_flag);
            check_field("halted", e.halted, rsp_data.halted);
            check_field("right_next", e.right_next, rsp_data.right_next);
            check_field("executed_opcode", e.executed_opcode, rsp_data.executed_opcode);
            check_field("div_zero", e.div_zero, rsp_data.div_zero);
         end
      end
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_type dz_row;
      int unsigned wait_cnt;
      bit drained;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      idle_pct = 35;
      drained  = 1'b0;
      n_items = 0; n_steps = 0; n_checked = 0; n_errors = 0; n_divzero = 0; n_jumps = 0;
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      pc_q = '0; acc_a_q = '0; acc_b_q = '0; right_half_q = '0;
      eq_q = 0; lt_q = 0; gt_q = 0; pend_q = 0; halt_q = 0;

      // divia by zero lands as the right half of the second word
      dz_row                 = '0;
      dz_row.prog_counter    = 11'd8;
      dz_row.acc_a_out       = 16'hFFFF;
      dz_row.acc_b_out       = 16'hFFFF;
      dz_row.executed_opcode = OP_DIVIA;
      dz_row.div_zero        = 1'b1;

      add_write(11'h000, 8'h00, 1'b1);
      add_write(11'h7FF, 8'hFF);
      add_write(11'h7FE, 8'h08);                // nop at the top, wraps into word 0
      add_half(11'd0, encode(OP_MOVIAL, 11'h0FF));
      add_half(11'd2, encode(OP_MOVIAH, 11'h0FF));
      add_half(11'd4, encode(OP_XCHG, 11'h000));
      add_half(11'd6, encode(OP_DIVIA, 11'h000));
      add_half(11'd8, encode(OP_CMP, 11'h000));
      add_half(11'd10, encode(OP_JMP, 11'h7FE));
      add_step();
      add_step();
      add_step();
      add_step(1'b1, dz_row);
      add_step();
      add_step();
      add_step();
      add_step();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_table[i]) issue(stim_table[i].req, stim_table[i].known, stim_table[i].rsp);

      while (n_items < RAND_ITEMS) begin
         if (n_items > 2 * RAND_ITEMS / 3) idle_pct = 0;
         else if (n_items > RAND_ITEMS / 3) idle_pct = 57;
         // hold the sender once until every outstanding result is back
         if (!drained && n_items > RAND_ITEMS / 2) begin
            drained = 1'b1;
            start <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 20) begin
            if ($urandom_range(1) != 0) write_byte(11'($urandom), 8'($urandom));
            else write_byte(pc_q + 11'($urandom_range(0, 7)), 8'($urandom));
         end else begin
            if (!pend_q) begin
               patch_half(pc_q, $urandom_range(9) == 0);
               patch_half(pc_q + 11'd2, $urandom_range(9) == 0);
            end
            step_cpu();
         end
      end

      // finish a pending right half, then halt and poke the halted machine
      if (pend_q) step_cpu();
      write_byte(pc_q, {OP_HLT, 3'b000});
      step_cpu();
      step_cpu();
      write_byte(11'h155, 8'hAA);
      step_cpu();
      @(posedge clock);
      start <= 1'b0;

      wait_cnt = 0;
      while (expected_q.size() != 0 && wait_cnt < 100000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (60) @(posedge clock);

      $display("ran %0d requests, %0d instruction steps, %0d results checked",
               n_items, n_steps, n_checked);
      $display("taken jumps %0d, divides by zero %0d, mismatches %0d",
               n_jumps, n_divzero, n_errors);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/twacpu_pkg.sv
rtl/twacpu_dpath.sv
rtl/twacpu_ctrl.sv
rtl/two_slot_word_accumulator_cpu_top.sv
rtl/twacpu_checker.sv
sim/tb.sv
